### src/qtl_pkg.sv
// shared types, character constants and keyword helpers for the query token lexer
package qtl_pkg;

  localparam int unsigned MAX_RES = 4;
  localparam int unsigned RES_IDX_W = 2;
  localparam int unsigned CNT_W = 3;
  localparam int unsigned KW_NUM = 8;
  localparam int unsigned KW_MAX_LEN = 5;

  typedef enum logic [4:0] {
    K_END, K_IDENT, K_INT, K_FLOAT, K_STRING,
    K_AND, K_OR, K_NOT, K_IN, K_LIKE, K_ILIKE, K_TRUE, K_FALSE,
    K_EQ, K_NE, K_GT, K_LT, K_GE, K_LE,
    K_TILDE, K_TILDE_STAR, K_BANG_TILDE, K_BANG_TILDE_STAR,
    K_LPAREN, K_RPAREN, K_LBRACK, K_RBRACK, K_COMMA
  } kind_e;

  typedef enum logic [1:0] {
    E_NONE, E_UNTERM, E_UNEXP, E_TOO_LONG
  } err_e;

  typedef struct packed {
    kind_e       kind;
    logic [15:0] column;
    logic [15:0] length;
    err_e        err;
    logic        last;
  } res_t;

  typedef struct packed {
    res_t [MAX_RES-1:0] res;
    logic [CNT_W-1:0]   cnt;
  } bundle_t;

  localparam logic [7:0] CH_EQ    = "=";
  localparam logic [7:0] CH_BANG  = "!";
  localparam logic [7:0] CH_GT    = ">";
  localparam logic [7:0] CH_LT    = "<";
  localparam logic [7:0] CH_TILDE = "~";
  localparam logic [7:0] CH_STAR  = "*";
  localparam logic [7:0] CH_LPAR  = "(";
  localparam logic [7:0] CH_RPAR  = ")";
  localparam logic [7:0] CH_LBRK  = "[";
  localparam logic [7:0] CH_RBRK  = "]";
  localparam logic [7:0] CH_COMMA = ",";
  localparam logic [7:0] CH_MINUS = "-";
  localparam logic [7:0] CH_PLUS  = "+";
  localparam logic [7:0] CH_DOT   = ".";
  localparam logic [7:0] CH_DQ    = 8'h22;
  localparam logic [7:0] CH_SQ    = 8'h27;
  localparam logic [7:0] CH_BSL   = 8'h5C;
  localparam logic [7:0] CH_UNDER = "_";
  localparam logic [7:0] CH_SPACE = " ";
  localparam logic [7:0] CH_LO_E  = "e";
  localparam logic [7:0] CH_UP_E  = "E";

  localparam logic [2:0] KW_LEN [KW_NUM] = '{3'd3, 3'd2, 3'd3, 3'd2, 3'd4, 3'd5, 3'd4, 3'd5};

  localparam logic [7:0] KW_CHR [KW_NUM][KW_MAX_LEN] = '{
    '{"a", "n", "d", 8'h00, 8'h00},
    '{"o", "r", 8'h00, 8'h00, 8'h00},
    '{"n", "o", "t", 8'h00, 8'h00},
    '{"i", "n", 8'h00, 8'h00, 8'h00},
    '{"l", "i", "k", "e", 8'h00},
    '{"i", "l", "i", "k", "e"},
    '{"t", "r", "u", "e", 8'h00},
    '{"f", "a", "l", "s", "e"}
  };

  function automatic logic is_digit(logic [7:0] c);
    return (c >= "0") && (c <= "9");
  endfunction

  function automatic logic is_alpha(logic [7:0] c);
    return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
  endfunction

  function automatic logic is_space(logic [7:0] c);
    return (c == CH_SPACE) || ((c >= 8'd9) && (c <= 8'd13));
  endfunction

  function automatic logic is_num_char(logic [7:0] c);
    return is_digit(c) || (c == CH_DOT) || (c == CH_LO_E) || (c == CH_UP_E) ||
           (c == CH_PLUS) || (c == CH_MINUS);
  endfunction

  function automatic logic ident_tail_char(logic [7:0] c);
    return is_alpha(c) || is_digit(c) || (c == CH_UNDER) || (c == CH_DOT);
  endfunction

  function automatic logic [7:0] to_lower(logic [7:0] c);
    return ((c >= "A") && (c <= "Z")) ? c + 8'd32 : c;
  endfunction

  // keywords that still match after character lc at offset off
  function automatic logic [KW_NUM-1:0] kw_keep(logic [7:0] lc, logic [2:0] off);
    logic [KW_NUM-1:0] keep;
    keep = '0;
    for (int k = 0; k < KW_NUM; k++) begin
      if (off < KW_LEN[k]) begin
        keep[k] = (KW_CHR[k][off] == lc);
      end
    end
    return keep;
  endfunction

  // lowest surviving keyword whose length matches, else plain identifier
  function automatic kind_e ident_kind(logic [KW_NUM-1:0] mask, logic short_len,
                                       logic [2:0] len);
    kind_e kind;
    kind = K_IDENT;
    for (int k = KW_NUM - 1; k >= 0; k--) begin
      if (short_len && mask[k] && (len == KW_LEN[k])) begin
        kind = kind_e'(5'(K_AND) + 5'(k));
      end
    end
    return kind;
  endfunction

  function automatic res_t mk_res(kind_e kind, logic [15:0] column, logic [15:0] length,
                                  err_e err, logic last);
    res_t r;
    r.kind   = kind;
    r.column = column;
    r.length = length;
    r.err    = err;
    r.last   = last;
    return r;
  endfunction

endpackage

### src/qtl_core.sv
// input register, lexer state and per-byte next-state and token logic
module qtl_core import qtl_pkg::*; #(
  parameter int unsigned POSITION_WIDTH = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] byte_value_i,
  input  logic       end_of_input_i,
  input  logic       obuf_ready_i,
  output logic       load_o,
  output bundle_t    bundle_o
);

  typedef logic [POSITION_WIDTH-1:0] pos_t;
  localparam pos_t POS_MAX = '1;
  localparam pos_t POS_ONE = pos_t'(1);
  localparam pos_t POS_FIVE = pos_t'(5);
  localparam pos_t POS_EIGHT = pos_t'(8);

  typedef enum logic [3:0] {
    M_IDLE, M_EQ, M_BANG, M_BANGTILDE, M_GT, M_LT, M_TILDE, M_MINUS,
    M_NUMBER, M_STRING, M_IDENT, M_SUFFIXED, M_BRACKET
  } mode_e;

  logic              in_vq, in_vd;
  logic [7:0]        byte_q;
  logic              eoi_q;
  mode_e             mode_q, mode_d;
  pos_t              tok_q, tok_d;
  pos_t              pos_q, pos_d;
  pos_t              brk_q, brk_d;
  logic              qs_q, qs_d;
  logic              esc_q, esc_d;
  logic              flt_q, flt_d;
  logic              err_q, err_d;
  logic [KW_NUM-1:0] kw_q, kw_d;

  logic              adv;
  logic [7:0]        c;
  pos_t              ident_end, ilen, koff_full, ilen_brk;
  logic [2:0]        koff;
  kind_e             ikind;
  logic              brk_gap;
  res_t [MAX_RES-1:0] res;
  logic [CNT_W-1:0]  n;
  logic              num_go, idle_go;

  assign adv        = in_vq && obuf_ready_i;
  assign in_ready_o = !in_vq || adv;
  assign load_o     = adv;
  assign in_vd      = (in_valid_i && in_ready_o) ? 1'b1 : (adv ? 1'b0 : in_vq);

  assign c         = byte_q;
  assign ident_end = (mode_q == M_BRACKET) ? brk_q : pos_q;
  assign ilen      = ident_end - tok_q;
  assign ikind     = ident_kind(kw_q, ilen < POS_EIGHT, ilen[2:0]);
  assign koff_full = pos_q - tok_q;
  assign koff      = (koff_full < POS_FIVE) ? koff_full[2:0] : 3'd7;
  assign brk_gap   = pos_q > (brk_q + POS_ONE);
  assign ilen_brk  = pos_q - brk_q - POS_ONE;

  always_comb begin
    mode_d  = mode_q;
    tok_d   = tok_q;
    pos_d   = pos_q;
    brk_d   = brk_q;
    qs_d    = qs_q;
    esc_d   = esc_q;
    flt_d   = flt_q;
    err_d   = err_q;
    kw_d    = kw_q;
    res     = '0;
    n       = '0;
    num_go  = 1'b0;
    idle_go = 1'b0;

    if (eoi_q) begin
      if (!err_q) begin
        unique case (mode_q)
          M_EQ, M_BANG, M_MINUS: begin
            res[n[RES_IDX_W-1:0]] = mk_res(K_END, 16'(tok_q), 16'd1, E_UNEXP, 1'b1);
            n = n + 3'd1;
          end
          M_STRING: begin
            res[n[RES_IDX_W-1:0]] = mk_res(K_END, 16'(tok_q), 16'(pos_q - tok_q),
                                           E_UNTERM, 1'b1);
            n = n + 3'd1;
          end
          M_BANGTILDE: begin
            res[n[RES_IDX_W-1:0]] = mk_res(K_BANG_TILDE, 16'(tok_q), 16'd2, E_NONE, 1'b0);
            n = n + 3'd1;
          end
          M_GT: begin
            res[n[RES_IDX_W-1:0]] = mk_res(K_GT, 16'(tok_q), 16'd1, E_NONE, 1'b0);
            n = n + 3'd1;
          end
          M_LT: begin
            res[n[RES_IDX_W-1:0]] = mk_res(K_LT, 16'(tok_q), 16'd1, E_NONE, 1'b0);
            n = n + 3'd1;
          end
          M_TILDE: begin
            res[n[RES_IDX_W-1:0]] = mk_res(K_TILDE, 16'(tok_q), 16'd1, E_NONE, 1'b0);
            n = n + 3'd1;
          end
          M_NUMBER: begin
            res[n[RES_IDX_W-1:0]] = mk_res(flt_q ? K_FLOAT : K_INT, 16'(tok_q),
                                           16'(pos_q - tok_q), E_NONE, 1'b0);
            n = n + 3'd1;
          end
          M_IDENT, M_SUFFIXED: begin
            res[n[RES_IDX_W-1:0]] = mk_res(ikind, 16'(tok_q), 16'(ilen), E_NONE, 1'b0);
            n = n + 3'd1;
          end
          M_BRACKET: begin
            res[n[RES_IDX_W-1:0]] = mk_res(ikind, 16'(tok_q), 16'(ilen), E_NONE, 1'b0);
            n = n + 3'd1;
            res[n[RES_IDX_W-1:0]] = mk_res(K_LBRACK, 16'(brk_q), 16'd1, E_NONE, 1'b0);
            n = n + 3'd1;
            if (brk_gap) begin
              res[n[RES_IDX_W-1:0]] = mk_res(K_INT, 16'(brk_q + POS_ONE), 16'(ilen_brk),
                                             E_NONE, 1'b0);
              n = n + 3'd1;
            end
          end
          default: ;
        endcase
        // end token unless the flush itself failed
        if (!((mode_q == M_EQ) || (mode_q == M_BANG) || (mode_q == M_MINUS) ||
              (mode_q == M_STRING))) begin
          res[n[RES_IDX_W-1:0]] = mk_res(K_END, 16'(pos_q), 16'd0, E_NONE, 1'b1);
          n = n + 3'd1;
        end
      end
      mode_d = M_IDLE;
      tok_d  = '0;
      pos_d  = '0;
      brk_d  = '0;
      qs_d   = 1'b0;
      esc_d  = 1'b0;
      flt_d  = 1'b0;
      err_d  = 1'b0;
      kw_d   = '1;
    end else if (!err_q) begin
      if (pos_q == POS_MAX) begin
        res[n[RES_IDX_W-1:0]] = mk_res(K_END, 16'(pos_q), 16'd1, E_TOO_LONG, 1'b1);
        n = n + 3'd1;
        err_d  = 1'b1;
        mode_d = M_IDLE;
      end else begin
        pos_d = pos_q + POS_ONE;
        unique case (mode_q)
          M_IDLE: idle_go = 1'b1;
          M_EQ: begin
            mode_d = M_IDLE;
            if (c == CH_EQ) begin
              res[n[RES_IDX_W-1:0]] = mk_res(K_EQ, 16'(tok_q), 16'd2, E_NONE, 1'b0);
              n = n + 3'd1;
            end else begin
              res[n[RES_IDX_W-1:0]] = mk_res(K_END, 16'(tok_q), 16'd1, E_UNEXP, 1'b1);
              n = n + 3'd1;
              err_d = 1'b1;
            end
          end
          M_BANG: begin
            if (c == CH_EQ) begin
              res[n[RES_IDX_W-1:0]] = mk_res(K_NE, 16'(tok_q), 16'd2, E_NONE, 1'b0);
              n = n + 3'd1;
              mode_d = M_IDLE;
            end else if (c == CH_TILDE) begin
              mode_d = M_BANGTILDE;
            end else begin
              res[n[RES_IDX_W-1:0]] = mk_res(K_END, 16'(tok_q), 16'd1, E_UNEXP, 1'b1);
              n = n + 3'd1;
              err_d  = 1'b1;
              mode_d = M_IDLE;
            end
          end
          M_BANGTILDE: begin
            mode_d = M_IDLE;
            if (c == CH_STAR) begin
              res[n[RES_IDX_W-1:0]] = mk_res(K_BANG_TILDE_STAR, 16'(tok_q), 16'd3,
                                             E_NONE, 1'b0);
              n = n + 3'd1;
            end else begin
              res[n[RES_IDX_W-1:0]] = mk_res(K_BANG_TILDE, 16'(tok_q), 16'd2, E_NONE, 1'b0);
              n = n + 3'd1;
              idle_go = 1'b1;
            end
          end
          M_GT: begin
            mode_d = M_IDLE;
            if (c == CH_EQ) begin
              res[n[RES_IDX_W-1:0]] = mk_res(K_GE, 16'(tok_q), 16'd2, E_NONE, 1'b0);
              n = n + 3'd1;
            end else begin
              res[n[RES_IDX_W-1:0]] = mk_res(K_GT, 16'(tok_q), 16'd1, E_NONE, 1'b0);
              n = n + 3'd1;
              idle_go = 1'b1;
            end
          end
          M_LT: begin
            mode_d = M_IDLE;
            if (c == CH_EQ) begin
              res[n[RES_IDX_W-1:0]] = mk_res(K_LE, 16'(tok_q), 16'd2, E_NONE, 1'b0);
              n = n + 3'd1;
            end else begin
              res[n[RES_IDX_W-1:0]] = mk_res(K_LT, 16'(tok_q), 16'd1, E_NONE, 1'b0);
              n = n + 3'd1;
              idle_go = 1'b1;
            end
          end
          M_TILDE: begin
            mode_d = M_IDLE;
            if (c == CH_STAR) begin
              res[n[RES_IDX_W-1:0]] = mk_res(K_TILDE_STAR, 16'(tok_q), 16'd2, E_NONE, 1'b0);
              n = n + 3'd1;
            end else begin
              res[n[RES_IDX_W-1:0]] = mk_res(K_TILDE, 16'(tok_q), 16'd1, E_NONE, 1'b0);
              n = n + 3'd1;
              idle_go = 1'b1;
            end
          end
          M_MINUS: begin
            if (is_digit(c)) begin
              flt_d  = 1'b0;
              mode_d = M_NUMBER;
            end else begin
              res[n[RES_IDX_W-1:0]] = mk_res(K_END, 16'(tok_q), 16'd1, E_UNEXP, 1'b1);
              n = n + 3'd1;
              err_d  = 1'b1;
              mode_d = M_IDLE;
            end
          end
          M_NUMBER: num_go = 1'b1;
          M_STRING: begin
            if (esc_q) begin
              esc_d = 1'b0;
            end else if (c == CH_BSL) begin
              esc_d = 1'b1;
            end else if (c == (qs_q ? CH_SQ : CH_DQ)) begin
              res[n[RES_IDX_W-1:0]] = mk_res(K_STRING, 16'(tok_q),
                                             16'(pos_q - tok_q - POS_ONE), E_NONE, 1'b0);
              n = n + 3'd1;
              mode_d = M_IDLE;
            end
          end
          M_IDENT, M_SUFFIXED: begin
            if ((mode_q == M_IDENT) && ident_tail_char(c)) begin
              kw_d = kw_q & kw_keep(to_lower(c), koff);
            end else if (c == CH_LBRK) begin
              brk_d  = pos_q;
              mode_d = M_BRACKET;
            end else begin
              res[n[RES_IDX_W-1:0]] = mk_res(ikind, 16'(tok_q), 16'(ilen), E_NONE, 1'b0);
              n = n + 3'd1;
              idle_go = 1'b1;
            end
          end
          M_BRACKET: begin
            if (is_digit(c)) begin
              mode_d = M_BRACKET;
            end else if ((c == CH_RBRK) && brk_gap) begin
              kw_d   = '0;
              mode_d = M_SUFFIXED;
            end else begin
              // failed suffix: identifier, left bracket, then digits as a number
              res[n[RES_IDX_W-1:0]] = mk_res(ikind, 16'(tok_q), 16'(ilen), E_NONE, 1'b0);
              n = n + 3'd1;
              res[n[RES_IDX_W-1:0]] = mk_res(K_LBRACK, 16'(brk_q), 16'd1, E_NONE, 1'b0);
              n = n + 3'd1;
              if (brk_gap) begin
                tok_d  = brk_q + POS_ONE;
                flt_d  = 1'b0;
                num_go = 1'b1;
              end else begin
                idle_go = 1'b1;
              end
            end
          end
          default: idle_go = 1'b1;
        endcase

        if (num_go) begin
          if (is_num_char(c)) begin
            mode_d = M_NUMBER;
            if ((c == CH_DOT) || (c == CH_LO_E) || (c == CH_UP_E)) begin
              flt_d = 1'b1;
            end
          end else begin
            res[n[RES_IDX_W-1:0]] = mk_res(flt_d ? K_FLOAT : K_INT, 16'(tok_d),
                                           16'(pos_q - tok_d), E_NONE, 1'b0);
            n = n + 3'd1;
            idle_go = 1'b1;
          end
        end

        if (idle_go) begin
          tok_d  = pos_q;
          mode_d = M_IDLE;
          if (is_space(c)) begin
            mode_d = M_IDLE;
          end else if (c == CH_EQ) begin
            mode_d = M_EQ;
          end else if (c == CH_BANG) begin
            mode_d = M_BANG;
          end else if (c == CH_GT) begin
            mode_d = M_GT;
          end else if (c == CH_LT) begin
            mode_d = M_LT;
          end else if (c == CH_TILDE) begin
            mode_d = M_TILDE;
          end else if (c == CH_MINUS) begin
            mode_d = M_MINUS;
          end else if (c == CH_LPAR) begin
            res[n[RES_IDX_W-1:0]] = mk_res(K_LPAREN, 16'(pos_q), 16'd1, E_NONE, 1'b0);
            n = n + 3'd1;
          end else if (c == CH_RPAR) begin
            res[n[RES_IDX_W-1:0]] = mk_res(K_RPAREN, 16'(pos_q), 16'd1, E_NONE, 1'b0);
            n = n + 3'd1;
          end else if (c == CH_LBRK) begin
            res[n[RES_IDX_W-1:0]] = mk_res(K_LBRACK, 16'(pos_q), 16'd1, E_NONE, 1'b0);
            n = n + 3'd1;
          end else if (c == CH_RBRK) begin
            res[n[RES_IDX_W-1:0]] = mk_res(K_RBRACK, 16'(pos_q), 16'd1, E_NONE, 1'b0);
            n = n + 3'd1;
          end else if (c == CH_COMMA) begin
            res[n[RES_IDX_W-1:0]] = mk_res(K_COMMA, 16'(pos_q), 16'd1, E_NONE, 1'b0);
            n = n + 3'd1;
          end else if ((c == CH_DQ) || (c == CH_SQ)) begin
            qs_d   = (c == CH_SQ);
            esc_d  = 1'b0;
            mode_d = M_STRING;
          end else if (is_digit(c)) begin
            flt_d  = 1'b0;
            mode_d = M_NUMBER;
          end else if (is_alpha(c) || (c == CH_UNDER)) begin
            kw_d   = kw_keep(to_lower(c), 3'd0);
            mode_d = M_IDENT;
          end else begin
            res[n[RES_IDX_W-1:0]] = mk_res(K_END, 16'(pos_q), 16'd1, E_UNEXP, 1'b1);
            n = n + 3'd1;
            err_d = 1'b1;
          end
        end
      end
    end
  end

  assign bundle_o.res = res;
  assign bundle_o.cnt = n;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vq  <= 1'b0;
      mode_q <= M_IDLE;
      tok_q  <= '0;
      pos_q  <= '0;
      brk_q  <= '0;
      qs_q   <= 1'b0;
      esc_q  <= 1'b0;
      flt_q  <= 1'b0;
      err_q  <= 1'b0;
      kw_q   <= '1;
    end else begin
      in_vq <= in_vd;
      if (adv) begin
        mode_q <= mode_d;
        tok_q  <= tok_d;
        pos_q  <= pos_d;
        brk_q  <= brk_d;
        qs_q   <= qs_d;
        esc_q  <= esc_d;
        flt_q  <= flt_d;
        err_q  <= err_d;
        kw_q   <= kw_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      byte_q <= byte_value_i;
      eoi_q  <= end_of_input_i;
    end
  end

endmodule

### src/qtl_obuf.sv
// result bundle register drained one token per output transfer
module qtl_obuf import qtl_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    load_i,
  input  bundle_t bundle_i,
  output logic    ready_o,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  output res_t    out_res_o
);

  res_t [MAX_RES-1:0]   res_q;
  logic [CNT_W-1:0]     cnt_q;
  logic [RES_IDX_W-1:0] idx_q;
  logic                 take, take_last;

  assign out_valid_o = (cnt_q != '0);
  assign out_res_o   = res_q[idx_q];
  assign take        = out_valid_o && out_ready_i;
  assign take_last   = take && (({1'b0, idx_q} + 3'd1) == cnt_q);
  assign ready_o     = !out_valid_o || take_last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      idx_q <= '0;
    end else if (load_i) begin
      cnt_q <= bundle_i.cnt;
      idx_q <= '0;
    end else if (take_last) begin
      cnt_q <= '0;
      idx_q <= '0;
    end else if (take) begin
      idx_q <= idx_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= bundle_i.res;
    end
  end

endmodule

### src/query_token_lexer.sv
// query token lexer top level: input register, lexer core and result buffer
//
// streaming lexer for filter queries, one byte per input transfer; a transfer with
// end_of_input_i set closes the query, flushes any pending token, emits END (column =
// byte count, length 0) and returns the lexer to its reset state. while the output is
// not stalled, a byte that gives at most one token is taken every cycle; a byte that
// gives k tokens (k up to 4, e.g. a failed bracket suffix followed by punctuation) holds
// the input side until all k are drained, since the single output port drains the
// per-byte result bundle one token a cycle while out_ready_i is high. a byte passes the
// input register, then the result register. after an error result (last_of_query_o with
// a nonzero error_code_o) bytes are dropped silently until the end transfer, which then
// emits nothing. tokens emitted before an error are not retracted. positions are
// POSITION_WIDTH bits wide; column_o and text_length_o carry the low 16 bits.
module query_token_lexer import qtl_pkg::*; #(
  parameter int unsigned POSITION_WIDTH = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  byte_value_i,
  input  logic        end_of_input_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [4:0]  token_kind_o,
  output logic [15:0] column_o,
  output logic [15:0] text_length_o,
  output logic [1:0]  error_code_o,
  output logic        last_of_query_o
);

  // handshake between core and result buffer
  logic    obuf_ready;
  logic    load;
  bundle_t bundle;
  res_t    out_res;

  // lexer state and per-byte token generation
  qtl_core #(
    .POSITION_WIDTH(POSITION_WIDTH)
  ) u_core (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .byte_value_i   (byte_value_i),
    .end_of_input_i (end_of_input_i),
    .obuf_ready_i   (obuf_ready),
    .load_o         (load),
    .bundle_o       (bundle)
  );

  // up to four tokens per byte, sent one per output transfer
  qtl_obuf u_obuf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (load),
    .bundle_i    (bundle),
    .ready_o     (obuf_ready),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_res_o   (out_res)
  );

  // error results carry kind END and the error span in the length field
  assign token_kind_o    = out_res.kind;
  assign column_o        = out_res.column;
  assign text_length_o   = out_res.length;
  assign error_code_o    = out_res.err;
  assign last_of_query_o = out_res.last;

endmodule

### src/qtl_checker.sv
// port-level checks for the query token lexer and their bind
module qtl_checker import qtl_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [4:0]  token_kind_i,
  input logic [15:0] column_i,
  input logic [15:0] text_length_i,
  input logic [1:0]  error_code_i,
  input logic        last_of_query_i
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(token_kind_i) &&
      $stable(column_i) && $stable(text_length_i) && $stable(error_code_i) &&
      $stable(last_of_query_i))
    else $error("output token changed while stalled");

  a_err_form: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (error_code_i != E_NONE) |-> (token_kind_i == K_END) && last_of_query_i)
    else $error("error result not marked as final END");

  a_end_form: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && last_of_query_i && (error_code_i == E_NONE) |->
      (token_kind_i == K_END) && (text_length_i == 16'd0))
    else $error("END token has bad kind or length");

  a_tok_form: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (token_kind_i != K_END) |-> !last_of_query_i && (error_code_i == E_NONE))
    else $error("ordinary token flagged as last or error");

  a_punct_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && ((token_kind_i == K_LPAREN) || (token_kind_i == K_RPAREN) ||
      (token_kind_i == K_LBRACK) || (token_kind_i == K_RBRACK) ||
      (token_kind_i == K_COMMA) || (token_kind_i == K_GT) ||
      (token_kind_i == K_LT) || (token_kind_i == K_TILDE)) |-> (text_length_i == 16'd1))
    else $error("single-character token with length other than one");

endmodule

bind query_token_lexer qtl_checker u_qtl_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .out_valid_i     (out_valid_o),
  .out_ready_i     (out_ready_i),
  .token_kind_i    (token_kind_o),
  .column_i        (column_o),
  .text_length_i   (text_length_o),
  .error_code_i    (error_code_o),
  .last_of_query_i (last_of_query_o)
);
